### hdl/bpk_pkg.sv
// Shared types and constants for the LSB-first bit packer.
package bpk_pkg;

  localparam int unsigned MaxWidth    = 32;
  localparam int unsigned ResidualW   = 32;
  localparam int unsigned CfgW        = 6;
  localparam int unsigned ByteW       = 8;
  // Accumulator holds up to seven leftover bits plus one full residual.
  localparam int unsigned AccW        = ResidualW + ByteW - 1;
  localparam int unsigned CountW      = 6;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCountW = $clog2(QueueDepth + 1);

  // One classified residual waiting to be packed.
  typedef struct packed {
    logic [ResidualW-1:0] value;   // already masked to the width
    logic [CountW-1:0]    width;   // saturated, 0..MaxWidth
    logic                 last;    // closes the block
  } bpk_entry_t;

endpackage

### hdl/bpk_front.sv
// Front end: width register, width saturation and residual masking.
module bpk_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bpk_pkg::CfgW-1:0]         cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bpk_pkg::ResidualW-1:0]    residual_i,
  input  logic                             block_end_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output bpk_pkg::bpk_entry_t              q_entry_o
);
  import bpk_pkg::*;

  logic [CfgW-1:0]      bit_width_q;
  logic [CountW-1:0]    width_sat;
  logic [ResidualW:0]   mask_wide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_width_q <= '0;
    end else if (cfg_we_i) begin
      bit_width_q <= cfg_wdata_i;
    end
  end

  // Clamp oversize widths to the maximum.
  assign width_sat = (bit_width_q > CfgW'(MaxWidth)) ? CountW'(MaxWidth)
                                                      : CountW'(bit_width_q);

  assign mask_wide = ((ResidualW+1)'(1) << width_sat) - (ResidualW+1)'(1);

  assign in_ready_o       = !q_full_i;
  assign q_push_o         = in_valid_i && !q_full_i;
  assign q_entry_o.value  = residual_i & mask_wide[ResidualW-1:0];
  assign q_entry_o.width  = width_sat;
  assign q_entry_o.last   = block_end_i;

endmodule

### hdl/bpk_fifo.sv
// Short queue of classified residuals between front and back ends.
module bpk_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bpk_pkg::bpk_entry_t  push_entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output bpk_pkg::bpk_entry_t  head_o
);
  import bpk_pkg::*;

  bpk_entry_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCountW-1:0] count_q;

  assign full_o  = (count_q == QueueCountW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hdl/bpk_back.sv
// Back end: bit accumulator, byte emission and output register.
module bpk_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  bpk_pkg::bpk_entry_t           q_head_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpk_pkg::ByteW-1:0]     packed_byte_o,
  output logic                          byte_is_last_o
);
  import bpk_pkg::*;

  logic [AccW-1:0]   work_q, work_d;
  logic [CountW-1:0] bits_q, bits_d;
  logic              flush_q, flush_d;
  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic              last_q, last_d;

  logic              pending, merge, slot_free;
  logic [AccW-1:0]   c_work;
  logic [CountW-1:0] c_bits;
  logic              c_flush;

  // Work remains on the current item: a whole byte, or a partial to flush.
  assign pending   = (bits_q >= CountW'(ByteW)) || (flush_q && bits_q != '0);
  assign merge     = !pending && q_valid_i;
  assign q_pop_o   = merge;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    c_work  = work_q;
    c_bits  = bits_q;
    c_flush = flush_q;
    if (merge) begin
      c_work  = work_q | ({{(AccW-ResidualW){1'b0}}, q_head_i.value} << bits_q[2:0]);
      c_bits  = bits_q + q_head_i.width;
      c_flush = q_head_i.last;
    end
  end

  always_comb begin
    work_d      = c_work;
    bits_d      = c_bits;
    flush_d     = c_flush;
    byte_d      = byte_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (slot_free) begin
      if (c_bits >= CountW'(ByteW)) begin
        byte_d      = c_work[ByteW-1:0];
        last_d      = c_flush && (c_bits == CountW'(ByteW));
        out_valid_d = 1'b1;
        work_d      = c_work >> ByteW;
        bits_d      = c_bits - CountW'(ByteW);
      end else if (c_flush && c_bits != '0) begin
        byte_d      = c_work[ByteW-1:0];
        last_d      = 1'b1;
        out_valid_d = 1'b1;
        work_d      = '0;
        bits_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      bits_q      <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      work_q      <= work_d;
      bits_q      <= bits_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign packed_byte_o  = byte_q;
  assign byte_is_last_o = last_q;

endmodule

### hdl/lsb_first_variable_width_bit_packer.sv
// Top level of the LSB-first variable-width bit packer.
//
// Packs residuals into a continuous byte stream, lowest bit first, at the
// width held in the configuration register (0..63 written, values above 32
// behave as 32). Write the width with cfg_we_i/cfg_wdata_i while idle.
// Input channel: in_valid_i/in_ready_o carry residual_i and block_end_i.
// Output channel: out_valid_o/out_ready_i carry packed_byte_o and
// byte_is_last_o; byte_is_last_o flags the final byte of each block.
// A transaction marked block_end flushes leftover bits as a zero-padded byte.
// With the back end idle, the first byte of a transaction is registered in
// the queue entry, then in the output register. Throughput: one byte per
// cycle on the output port while out_ready_i stays high, set by the
// single-byte output register in the back end.
// The front end classifies transactions into a two-entry queue; the back
// end merges them into the accumulator and emits bytes. When the receiver
// stalls, hold the output byte; the back end stops, the queue fills and
// in_ready_o drops. Reset clears the width to zero, empties the accumulator
// and the queue, and drops out_valid_o.
module lsb_first_variable_width_bit_packer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpk_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [bpk_pkg::ResidualW-1:0] residual_i,
  input  logic                          block_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpk_pkg::ByteW-1:0]     packed_byte_o,
  output logic                          byte_is_last_o
);
  import bpk_pkg::*;

  bpk_entry_t push_entry, head_entry;
  logic       q_push, q_full, q_pop, q_valid;

  // Classify: saturate width, mask residual, push into the queue.
  bpk_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .residual_i  (residual_i),
    .block_end_i (block_end_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  // Decouple the two sides so each can stall on its own.
  bpk_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (head_entry)
  );

  // Accumulate bits and advance one byte per cycle unless the receiver stalls.
  bpk_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_head_i       (head_entry),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .packed_byte_o  (packed_byte_o),
    .byte_is_last_o (byte_is_last_o)
  );

endmodule
